// File: rtl/mck_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mck_pkg
// Shared types, constants and the Morse pattern lookup for the keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

    // widths of the beat fields
    localparam int CHAR_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int UNITS_W = 3;
    localparam int TIME_W  = 19;
    localparam int PAT_W   = 6;
    localparam int LEN_W   = 3;

    // case folding window and space code
    localparam logic [CHAR_W-1:0] FOLD_LO     = 8'd96;
    localparam logic [CHAR_W-1:0] FOLD_HI     = 8'd123;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;
    localparam logic [CHAR_W-1:0] SPACE_CODE  = 8'd32;

    // segment lengths in units
    localparam logic [UNITS_W-1:0] UNITS_DOT   = 3'd1;
    localparam logic [UNITS_W-1:0] UNITS_DASH  = 3'd3;
    localparam logic [UNITS_W-1:0] UNITS_OFF   = 3'd1;
    localparam logic [UNITS_W-1:0] UNITS_GAP   = 3'd2;
    localparam logic [UNITS_W-1:0] UNITS_SPACE = 3'd6;

    localparam logic [UNIT_W-1:0] UNIT_TIME_RST = 16'd85;

    // element pattern: dash = 1, first element in bit 0
    typedef struct packed {
        logic             known;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] dashes;
    } t_pattern;

    // controller to datapath
    typedef struct packed {
        logic               load;
        logic               shift;
        logic               emit;
        logic               key_on;
        logic [UNITS_W-1:0] units;
        logic               last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_space;
        logic known;
        logic elem_dash;
        logic last_elem;
        logic out_free;
    } t_sts;

    // fold lower case a to z onto upper case
    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] f;
        f = c;
        if ((c > FOLD_LO) && (c < FOLD_HI)) begin
            f = c - CASE_OFFSET;
        end
        return f;
    endfunction

    function automatic t_pattern mk(input logic [LEN_W-1:0] len,
                                    input logic [PAT_W-1:0] dashes);
        t_pattern p;
        p.known  = 1'b1;
        p.len    = len;
        p.dashes = dashes;
        return p;
    endfunction

    // international Morse table, takes a folded character
    function automatic t_pattern lookup(input logic [CHAR_W-1:0] c);
        t_pattern p;
        p = '0;
        case (c)
            "A": p = mk(3'd2, 6'b000010);
            "B": p = mk(3'd4, 6'b000001);
            "C": p = mk(3'd4, 6'b000101);
            "D": p = mk(3'd3, 6'b000001);
            "E": p = mk(3'd1, 6'b000000);
            "F": p = mk(3'd4, 6'b000100);
            "G": p = mk(3'd3, 6'b000011);
            "H": p = mk(3'd4, 6'b000000);
            "I": p = mk(3'd2, 6'b000000);
            "J": p = mk(3'd4, 6'b001110);
            "K": p = mk(3'd3, 6'b000101);
            "L": p = mk(3'd4, 6'b000010);
            "M": p = mk(3'd2, 6'b000011);
            "N": p = mk(3'd2, 6'b000001);
            "O": p = mk(3'd3, 6'b000111);
            "P": p = mk(3'd4, 6'b000110);
            "Q": p = mk(3'd4, 6'b001011);
            "R": p = mk(3'd3, 6'b000010);
            "S": p = mk(3'd3, 6'b000000);
            "T": p = mk(3'd1, 6'b000001);
            "U": p = mk(3'd3, 6'b000100);
            "V": p = mk(3'd4, 6'b001000);
            "W": p = mk(3'd3, 6'b000110);
            "X": p = mk(3'd4, 6'b001001);
            "Y": p = mk(3'd4, 6'b001101);
            "Z": p = mk(3'd4, 6'b000011);
            "0": p = mk(3'd5, 6'b011111);
            "1": p = mk(3'd5, 6'b011110);
            "2": p = mk(3'd5, 6'b011100);
            "3": p = mk(3'd5, 6'b011000);
            "4": p = mk(3'd5, 6'b010000);
            "5": p = mk(3'd5, 6'b000000);
            "6": p = mk(3'd5, 6'b000001);
            "7": p = mk(3'd5, 6'b000011);
            "8": p = mk(3'd5, 6'b000111);
            "9": p = mk(3'd5, 6'b001111);
            "?": p = mk(3'd6, 6'b001100);
            "=": p = mk(3'd5, 6'b010001);
            ",": p = mk(3'd6, 6'b110011);
            "/": p = mk(3'd5, 6'b001001);
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// File: rtl/mck_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mck_if
// Valid/ready channels of the keyer: character in, segment out, config write.
// ----------------------------------------------------------------------------
interface mck_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface mck_seg_if;
    logic        valid;
    logic        ready;
    logic        key_on;
    logic [2:0]  segment_units;
    logic [18:0] segment_time;
    logic        last;
    modport source (output valid, output key_on, output segment_units,
                    output segment_time, output last, input ready);
    modport sink   (input valid, input key_on, input segment_units,
                    input segment_time, input last, output ready);
endinterface

interface mck_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] unit_time;
    modport source (output valid, output unit_time, input ready);
    modport sink   (input valid, input unit_time, output ready);
endinterface
`default_nettype wire

// File: rtl/mck_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mck_ctrl
// Segment sequencer: steps through the elements of one character, one
// segment per free output slot.
// ----------------------------------------------------------------------------
module mck_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_char_valid,
    output logic               o_char_ready,
    input  mck_pkg::t_sts      i_sts,
    output mck_pkg::t_cmd      o_cmd
);
    import mck_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_ELEM_ON  = 5'b00010,
        S_ELEM_OFF = 5'b00100,
        S_GAP      = 5'b01000,
        S_SPACE    = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // next state and datapath commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_char_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_char_ready = 1'b1;
                if (i_char_valid) begin
                    if (i_sts.is_space) begin
                        n_state = S_SPACE;
                    end else if (i_sts.known) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_ELEM_ON;
                    end
                end
            end
            S_ELEM_ON: begin
                if (i_sts.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.key_on = 1'b1;
                    o_cmd.units  = i_sts.elem_dash ? UNITS_DASH : UNITS_DOT;
                    n_state      = S_ELEM_OFF;
                end
            end
            S_ELEM_OFF: begin
                if (i_sts.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.units = UNITS_OFF;
                    o_cmd.shift = 1'b1;
                    n_state     = i_sts.last_elem ? S_GAP : S_ELEM_ON;
                end
            end
            S_GAP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.units = UNITS_GAP;
                    o_cmd.last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_SPACE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.units = UNITS_SPACE;
                    o_cmd.last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a segment is only pushed into a free output slot
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("segment emitted into occupied output slot");

    // nothing is emitted while waiting for a character
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!o_cmd.emit && !o_cmd.shift))
        else $error("idle controller issued a segment");

    // the closing gap always returns to idle
    a_gap_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GAP && i_sts.out_free) |=> (r_state == S_IDLE))
        else $error("closing gap did not end the character");

    // only the final segment carries last
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> (r_state == S_IDLE))
        else $error("last flagged on a segment that is not final");

endmodule
`default_nettype wire

// File: rtl/mck_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mck_datapath
// Pattern lookup, element shift register, unit time register and the
// registered segment output with its tick multiply.
// ----------------------------------------------------------------------------
module mck_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [7:0]    i_char_code,
    input  wire logic          i_cfg_we,
    input  wire logic [15:0]   i_cfg_unit_time,
    input  wire logic          i_out_ready,
    input  mck_pkg::t_cmd      i_cmd,
    output mck_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    output logic               o_key_on,
    output logic [2:0]         o_segment_units,
    output logic [18:0]        o_segment_time,
    output logic               o_last
);
    import mck_pkg::*;

    logic [UNIT_W-1:0]  r_unit_time;
    logic [PAT_W-1:0]   r_pattern;
    logic [LEN_W-1:0]   r_elems_left;
    logic               r_out_valid;
    logic               r_key_on;
    logic [UNITS_W-1:0] r_units;
    logic [TIME_W-1:0]  r_time;
    logic               r_last;

    logic [CHAR_W-1:0]  w_folded;
    t_pattern           w_pat;
    logic [TIME_W-1:0]  w_time;

    // lookup of the character on the input channel
    assign w_folded = fold_case(i_char_code);
    assign w_pat    = lookup(w_folded);

    assign o_sts.is_space  = (w_folded == SPACE_CODE);
    assign o_sts.known     = w_pat.known;
    assign o_sts.elem_dash = r_pattern[0];
    assign o_sts.last_elem = (r_elems_left == LEN_W'(1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // segment ticks: units times unit time
    assign w_time = TIME_W'(i_cmd.units) * TIME_W'(r_unit_time);

    // unit time register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_time <= UNIT_TIME_RST;
        end else if (i_cfg_we) begin
            r_unit_time <= i_cfg_unit_time;
        end
    end

    // element shift register and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern    <= '0;
            r_elems_left <= '0;
        end else if (i_cmd.load) begin
            r_pattern    <= w_pat.dashes;
            r_elems_left <= w_pat.len;
        end else if (i_cmd.shift) begin
            r_pattern    <= r_pattern >> 1;
            r_elems_left <= r_elems_left - LEN_W'(1);
        end
    end

    // output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_key_on <= i_cmd.key_on;
            r_units  <= i_cmd.units;
            r_time   <= w_time;
            r_last   <= i_cmd.last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_key_on        = r_key_on;
    assign o_segment_units = r_units;
    assign o_segment_time  = r_time;
    assign o_last          = r_last;

    // a loaded pattern always holds at least one element
    a_load_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_elems_left != '0))
        else $error("empty pattern loaded");

    // shifting never runs past the last element
    a_shift_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift |-> (r_elems_left != '0))
        else $error("element count underflow");

    // a pending segment has one of the legal lengths
    a_units_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_units == UNITS_DOT || r_units == UNITS_GAP ||
                         r_units == UNITS_DASH || r_units == UNITS_SPACE))
        else $error("illegal segment length");

endmodule
`default_nettype wire

// File: rtl/morse_character_keyer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// morse_character_keyer
// International Morse encoder: one ASCII character in, key segments out.
// ----------------------------------------------------------------------------
// One character beat in produces its key segments on the output channel, one
// segment beat per cycle while the sink takes them. A character with n Morse
// elements gives 2n+1 segments: a key-on and a key-off segment per element,
// then the closing gap. A space gives one segment; an unknown character is
// taken and gives none. Output stalls hold the sequencer. The input is taken
// only between characters. unit_time may be written at any time the block is
// idle; its write channel is always ready.
module morse_character_keyer (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mck_char_if.sink  i_char,
    mck_cfg_if.sink   i_cfg,
    mck_seg_if.source o_seg
);
    import mck_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_char_ready;

    assign i_char.ready = w_char_ready;
    assign i_cfg.ready  = 1'b1;

    // sequencer
    mck_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_valid (i_char.valid),
        .o_char_ready (w_char_ready),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    // datapath
    mck_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_char_code     (i_char.char_code),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_unit_time (i_cfg.unit_time),
        .i_out_ready     (o_seg.ready),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_out_valid     (o_seg.valid),
        .o_key_on        (o_seg.key_on),
        .o_segment_units (o_seg.segment_units),
        .o_segment_time  (o_seg.segment_time),
        .o_last          (o_seg.last)
    );

endmodule
`default_nettype wire
